// ----- hdl/cdpd_pkg.sv -----
package cdpd_pkg;

    localparam int DAY_W    = 7;
    localparam int MONTH_W  = 7;
    localparam int YEAR_W   = 14;
    localparam int DIFF_W   = 22;
    localparam int LIMIT_W  = 12;
    localparam int NUM_W    = 23;   // day number, fits years up to 16383
    localparam int DOY_W    = 9;
    localparam int Q100_W   = 8;    // 16383 / 100 = 163
    localparam int YPX_W    = 13;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd120;

    // x / 100 == (x * 5243) >> 19, exact for x < 43690
    localparam logic [18:0] RECIP_100 = 19'd5243;
    localparam int          RECIP_SH  = 19;

    typedef enum logic [1:0] {
        ORD_EQUAL = 2'd0,
        ORD_EARLY = 2'd1,
        ORD_LATE  = 2'd2
    } t_order;

    // register index, taken from paddr word bits
    localparam logic REG_LIMIT = 1'b0;

    // per-stage advance enables of the date pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_adv;

    function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] x);
        logic [YEAR_W+RECIP_SH-1:0] p;
        p = (YEAR_W+RECIP_SH)'(x) * (YEAR_W+RECIP_SH)'(RECIP_100);
        return p[RECIP_SH +: Q100_W];
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [3:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            7'd2:                      r = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/cdpd_day_number.sv -----
module cdpd_day_number
    import cdpd_pkg::*;
(
    input  logic                 i_clk,
    input  t_adv                 i_adv,
    input  logic [DAY_W-1:0]     i_day,
    input  logic [MONTH_W-1:0]   i_month,
    input  logic [YEAR_W-1:0]    i_year,
    input  logic                 i_well_formed,
    output logic                 o_valid,
    output logic [NUM_W-1:0]     o_num
);

    // stage 1: fields, y-1 and the /100 quotients
    logic [DAY_W-1:0]   r_d;
    logic [MONTH_W-1:0] r_m;
    logic [YEAR_W-1:0]  r_y;
    logic               r_wf;
    logic [YEAR_W-1:0]  r_yp;
    logic [Q100_W-1:0]  r_qy;
    logic [Q100_W-1:0]  r_qyp;

    // stage 2: validity, day of year, year part
    logic               r_ok2;
    logic [DOY_W-1:0]   r_doy;
    logic [NUM_W-1:0]   r_yp365;
    logic [YPX_W-1:0]   r_ypx;

    // stage 3: day number
    logic               r_ok3;
    logic [NUM_W-1:0]   r_num;

    logic [YEAR_W-1:0]  n_yp;
    logic               div_100;
    logic               leap;
    logic [4:0]         len;
    logic               n_ok2;
    logic [DOY_W-1:0]   n_doy;

    assign n_yp = i_year - YEAR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_d   <= i_day;
            r_m   <= i_month;
            r_y   <= i_year;
            r_wf  <= i_well_formed;
            r_yp  <= n_yp;
            r_qy  <= div100(i_year);
            r_qyp <= div100(n_yp);
        end
    end

    always_comb begin
        div_100 = (r_y == YEAR_W'(YEAR_W'(r_qy) * YEAR_W'(100)));
        leap    = ((r_y[1:0] == 2'b00) && !div_100) || (div_100 && (r_qy[1:0] == 2'b00));
        len     = month_len(r_m, leap);
        n_ok2   = r_wf && (r_y != '0) && (r_m >= 7'd1) && (r_m <= 7'd12)
                  && (r_d >= 7'd1) && (r_d <= DAY_W'(len));
        n_doy   = days_before(r_m[3:0]) + DOY_W'(r_d)
                  + DOY_W'((r_m > 7'd2) && leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_ok2   <= n_ok2;
            r_doy   <= n_doy;
            r_yp365 <= NUM_W'(r_yp) * NUM_W'(365);
            // (y-1)/4 - (y-1)/100 + (y-1)/400, never negative
            r_ypx   <= YPX_W'(r_yp >> 2) - YPX_W'(r_qyp) + YPX_W'(r_qyp >> 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_ok3 <= r_ok2;
            r_num <= r_yp365 + NUM_W'(r_ypx) + NUM_W'(r_doy);
        end
    end

    assign o_valid = r_ok3;
    assign o_num   = r_num;

endmodule

// ----- hdl/calendar_date_pair_difference.sv -----
// Gregorian date-pair difference, one request per clock.
//
// Input channel (i_valid / o_ready): two dates, each day, month, year and a
// well-formed flag. Output channel (o_valid / i_ready): per-date validity,
// order of the pair (equal / first earlier / first later, compared on the raw
// year, month, day fields), low 22 bits of the absolute day count between the
// dates (0 if either date is invalid) and a flag that the count <= limit_days.
//
// Four register stages: /100 quotients, then validity, day of year and
// 365*(y-1), then the day number, then the subtract and limit compare into the
// output register; valid bits go r_v1, r_v2, r_v3, r_v4 (o_valid). Throughput
// is one request per cycle while i_ready is high; each stage carries its own
// valid bit and advances when it is empty or the stage after it advances.
//
// When the receiver holds i_ready low the output register holds its result
// and the stages behind it keep filling; o_ready falls only once all four
// stages are full. Reset empties the pipeline and sets limit_days to 120.
// limit_days sits at APB byte address 0; pready is always high.
module calendar_date_pair_difference
    import cdpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,

    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [DAY_W-1:0]     i_first_day,
    input  logic [MONTH_W-1:0]   i_first_month,
    input  logic [YEAR_W-1:0]    i_first_year,
    input  logic                 i_first_well_formed,
    input  logic [DAY_W-1:0]     i_second_day,
    input  logic [MONTH_W-1:0]   i_second_month,
    input  logic [YEAR_W-1:0]    i_second_year,
    input  logic                 i_second_well_formed,

    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_first_valid,
    output logic                 o_second_valid,
    output logic [1:0]           o_order,
    output logic [DIFF_W-1:0]    o_day_difference,
    output logic                 o_within_limit
);

    // ---- configuration register ----
    logic [LIMIT_W-1:0] r_limit;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LIMIT) ? PDATA_W'(r_limit) : '0;

    // ---- pipeline control ----
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv4;
    t_adv adv;

    always_comb begin
        adv4   = !r_v4 || i_ready;
        adv.s3 = !r_v3 || adv4;
        adv.s2 = !r_v2 || adv.s3;
        adv.s1 = !r_v1 || adv.s2;
    end

    assign o_ready = adv.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv.s1) r_v1 <= i_valid;
            if (adv.s2) r_v2 <= r_v1;
            if (adv.s3) r_v3 <= r_v2;
            if (adv4)   r_v4 <= r_v3;
        end
    end

    // ---- ordering on raw fields ----
    logic [DAY_W+MONTH_W+YEAR_W-1:0] key1, key2;
    t_order n_ord;
    t_order r_ord1, r_ord2, r_ord3, r_ord4;

    always_comb begin
        key1 = {i_first_year, i_first_month, i_first_day};
        key2 = {i_second_year, i_second_month, i_second_day};
        if (key1 == key2)     n_ord = ORD_EQUAL;
        else if (key1 < key2) n_ord = ORD_EARLY;
        else                  n_ord = ORD_LATE;
    end

    always_ff @(posedge i_clk) begin
        if (adv.s1) r_ord1 <= n_ord;
        if (adv.s2) r_ord2 <= r_ord1;
        if (adv.s3) r_ord3 <= r_ord2;
    end

    // ---- per-date day numbers (stages 1..3) ----
    logic               ok1, ok2;
    logic [NUM_W-1:0]   num1, num2;

    cdpd_day_number u_first (
        .i_clk         (i_clk),
        .i_adv         (adv),
        .i_day         (i_first_day),
        .i_month       (i_first_month),
        .i_year        (i_first_year),
        .i_well_formed (i_first_well_formed),
        .o_valid       (ok1),
        .o_num         (num1)
    );

    cdpd_day_number u_second (
        .i_clk         (i_clk),
        .i_adv         (adv),
        .i_day         (i_second_day),
        .i_month       (i_second_month),
        .i_year        (i_second_year),
        .i_well_formed (i_second_well_formed),
        .o_valid       (ok2),
        .o_num         (num2)
    );

    // ---- stage 4: difference and limit check ----
    logic [NUM_W-1:0]  n_diff;
    logic              r_ok_a, r_ok_b, r_within;
    logic [DIFF_W-1:0] r_diff;

    always_comb begin
        if (!(ok1 && ok2))    n_diff = '0;
        else if (num1 > num2) n_diff = num1 - num2;
        else                  n_diff = num2 - num1;
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_ok_a   <= ok1;
            r_ok_b   <= ok2;
            r_ord4   <= r_ord3;
            r_diff   <= n_diff[DIFF_W-1:0];
            // compare on the full count, before truncation
            r_within <= (n_diff <= NUM_W'(r_limit));
        end
    end

    assign o_valid          = r_v4;
    assign o_first_valid    = r_ok_a;
    assign o_second_valid   = r_ok_b;
    assign o_order          = r_ord4;
    assign o_day_difference = r_diff;
    assign o_within_limit   = r_within;

    // ---- assertions ----
    a_diff_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_day_difference != '0) |-> o_first_valid && o_second_valid)
        else $error("nonzero difference with an invalid date");

    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_order == ORD_EQUAL) && o_first_valid && o_second_valid
        |-> o_day_difference == '0)
        else $error("equal dates with nonzero difference");

    a_over_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_within_limit |-> o_first_valid && o_second_valid)
        else $error("limit exceeded with an invalid date");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && r_v4 && !i_ready |-> !o_ready)
        else $error("input taken while pipeline full and stalled");

endmodule
